### hw/rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants for the add-rotate generator
// Holds the generator constants, the operation codes, the controller state
// encoding and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    // Generator constants
    localparam int unsigned SEED_ROUNDS = 32;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned DIV_STEPS   = WORD_W;
    localparam int unsigned ROT_AMT     = 16;

    localparam logic [WORD_W-1:0] ZERO_SEED_WORD = 32'hdeadbeef;
    localparam logic [WORD_W-1:0] SEED_MIX_WORD  = 32'hbead29ba;

    // Round/step counter: wide enough for either count
    localparam int unsigned CNT_MAX = (SEED_ROUNDS > DIV_STEPS) ? SEED_ROUNDS : DIV_STEPS;
    localparam int unsigned CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    // Operation codes
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEED = 5'b00010,
        ST_ADV  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_WR   = 5'b10000
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_seed;
        logic load_range;
        logic advance;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl: sequencer for seeding, advancing and the bit-serial remainder
// Accepts one item at a time, counts seed rounds and divider steps, and
// issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          operation,
    output logic               in_stall,
    input  arp_pkg::sts_t      sts,
    output arp_pkg::cmd_t      cmd
);
    import arp_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               cnt_zero;

    assign cnt_zero = (cnt_reg == '0);

    // Take a new item only when idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state, counter and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_DRAW)
                    begin
                        cmd.load_range = 1'b1;
                        state_next     = ST_ADV;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        cnt_next      = CNT_W'(SEED_ROUNDS - 1);
                        state_next    = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.advance = 1'b1;
                if (cnt_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_ADV:
            begin
                cmd.advance  = 1'b1;
                cmd.div_load = 1'b1;
                cnt_next     = CNT_W'(DIV_STEPS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_zero)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/arp_dp.sv
// ----------------------------------------------------------------------------
// arp_dp: generator state words, restoring remainder unit and output register
// Advances the two state words, reduces word B by the range one bit a cycle
// and holds the finished result until the output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  arp_pkg::cmd_t                      cmd,
    output arp_pkg::sts_t                      sts,
    input  wire logic [arp_pkg::WORD_W-1:0]    operand_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [arp_pkg::WORD_W-1:0]         random_bits
);
    import arp_pkg::*;

    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] a_next;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] b_next;
    logic [WORD_W-1:0] range_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] res_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] adv_b;
    logic [WORD_W-1:0] adv_a;
    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;

    // Seed word, zero seed replaced
    assign seed_word = (operand_bits != '0) ? operand_bits : ZERO_SEED_WORD;

    // Advance step: B = A + rot16(B), A = A + B
    assign adv_b = a_reg + {b_reg[ROT_AMT-1:0], b_reg[WORD_W-1:ROT_AMT]};
    assign adv_a = a_reg + adv_b;

    // Restoring remainder step
    assign shifted  = {rem_reg, quo_reg[WORD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, range_reg};
    assign rem_next = diff[WORD_W+1] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];

    // Update state words
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        priority if (cmd.load_seed)
        begin
            a_next = seed_word;
            b_next = seed_word ^ SEED_MIX_WORD;
        end
        else if (cmd.advance)
        begin
            a_next = adv_a;
            b_next = adv_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // Latch range, load dividend, shift remainder
    always_ff @(posedge clk)
    begin
        if (cmd.load_range)
        begin
            range_reg <= operand_bits;
        end
        if (cmd.div_load)
        begin
            quo_reg <= adv_b;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            res_reg <= (range_reg != '0) ? rem_reg : '0;
        end
    end

    // Output valid: set on load, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign random_bits  = res_reg;

endmodule

`default_nettype wire

### hw/rtl/add_rotate_prng_with_range_top.sv
// ----------------------------------------------------------------------------
// add_rotate_prng_with_range_top: add-rotate generator with ranged draws
// Seed: accept, then SEED_ROUNDS (32) advance rounds, no result.
// Draw: accept, one advance, 32 remainder steps (one bit per cycle in the
// restoring unit), output load (held while the output is full and stalled),
// then the next item is accepted. The output register holds a result while
// the next item is taken. Reset (async, active low) clears both state words.
// ----------------------------------------------------------------------------
`default_nettype none

module add_rotate_prng_with_range_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [arp_pkg::WORD_W-1:0]    operand_bits,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [arp_pkg::WORD_W-1:0]         random_bits
);
    import arp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    arp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath
    arp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_bits  (random_bits)
    );

endmodule

`default_nettype wire
